>>> design/md5_message_digest_defines.svh
// ----------------------------------------------------------------------------
// MD5 digest assertion macros
// Shared assertion forms, clocked on i_clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH

// Property must hold at every edge outside reset.
`define MD5_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define MD5_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

>>> design/md5_pkg.sv
// ----------------------------------------------------------------------------
// MD5 package
// Types, constants and round tables shared by the MD5 digest modules.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned BANKS     = 2;
    localparam int unsigned RAM_DEPTH = BLK_WORDS * BANKS;
    localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS_LIMIT = 6'd56;

    localparam logic [31:0] SINE_ROM [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_ROM [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef enum logic {
        FR_IDLE,
        FR_PAD
    } t_front_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PRE0,
        BK_PRE1,
        BK_ROUND,
        BK_ADD,
        BK_OUT
    } t_back_state;

    // Front to queue: a block has been completed in the write bank.
    typedef struct packed {
        logic push;
        logic last;
    } t_blk_push;

    // Queue to back: oldest complete block.
    typedef struct packed {
        logic avail;
        logic last;
        logic bank;
    } t_blk_status;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [31:0]       data;
    } t_ram_wr;

    // Message word index used in round i.
    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] j;
        logic [3:0] g;
        j = i[3:0];
        case (i[5:4])
            2'd0:    g = j;
            2'd1:    g = 4'(j + (j << 2) + 4'd1);
            2'd2:    g = 4'(j + (j << 1) + 4'd5);
            2'd3:    g = 4'((j << 3) - j);
            default: g = j;
        endcase
        return g;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        return ROT_ROM[{i[5:4], i[1:0]}];
    endfunction

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

>>> design/md5_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module md5_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/md5_front.sv
// ----------------------------------------------------------------------------
// MD5 front end
// Packs message bytes into words, writes padding and length, hands blocks on.
// ----------------------------------------------------------------------------
module md5_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_byte_present,
    input  logic                 i_message_end,
    input  logic                 i_room,
    input  logic                 i_wbank,
    output md5_pkg::t_ram_wr     o_wr,
    output md5_pkg::t_blk_push   o_blk
);
    import md5_pkg::*;

    t_front_state r_state, n_state;
    logic [60:0]  r_count, n_count;
    logic [31:0]  r_word,  n_word;
    logic [3:0]   r_pad_w, n_pad_w;
    logic         r_first, n_first;
    logic         r_extra, n_extra;

    logic [31:0]  w_byte_word;
    logic [31:0]  w_pad_word;
    logic [63:0]  w_bits;
    logic [5:0]   w_pos_after;
    logic         w_accept;

    assign o_full   = (r_state != FR_IDLE) || !i_room;
    assign w_accept = i_push && !o_full;
    assign w_bits   = {r_count, 3'b000};

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_byte_word[8*k +: 8] = (2'(k) == r_count[1:0]) ? i_data_byte : r_word[8*k +: 8];
            if (2'(k) < r_count[1:0]) begin
                w_pad_word[8*k +: 8] = r_word[8*k +: 8];
            end else if (2'(k) == r_count[1:0]) begin
                w_pad_word[8*k +: 8] = PAD_BYTE;
            end else begin
                w_pad_word[8*k +: 8] = 8'h00;
            end
        end
    end

    assign w_pos_after = i_byte_present ? (r_count[5:0] + 6'd1) : r_count[5:0];

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_word  = r_word;
        n_pad_w = r_pad_w;
        n_first = r_first;
        n_extra = r_extra;
        o_wr    = '0;
        o_blk   = '0;
        case (r_state)
            FR_IDLE: begin
                if (w_accept) begin
                    if (i_byte_present) begin
                        n_word  = w_byte_word;
                        n_count = r_count + 61'd1;
                        if (r_count[1:0] == 2'd3) begin
                            o_wr.en   = 1'b1;
                            o_wr.addr = {i_wbank, r_count[5:2]};
                            o_wr.data = w_byte_word;
                        end
                        if (r_count[5:0] == 6'd63) begin
                            o_blk.push = 1'b1;
                        end
                    end
                    if (i_message_end) begin
                        n_state = FR_PAD;
                        n_first = 1'b1;
                        n_pad_w = w_pos_after[5:2];
                        n_extra = (w_pos_after >= LEN_POS_LIMIT);
                    end
                end
            end
            FR_PAD: begin
                if (i_room) begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = {i_wbank, r_pad_w};
                    if (r_first) begin
                        o_wr.data = w_pad_word;
                    end else if (!r_extra && r_pad_w == 4'd14) begin
                        o_wr.data = w_bits[31:0];
                    end else if (!r_extra && r_pad_w == 4'd15) begin
                        o_wr.data = w_bits[63:32];
                    end else begin
                        o_wr.data = '0;
                    end
                    n_first = 1'b0;
                    if (r_pad_w == 4'd15) begin
                        o_blk.push = 1'b1;
                        o_blk.last = !r_extra;
                        if (r_extra) begin
                            n_extra = 1'b0;
                            n_pad_w = '0;
                        end else begin
                            n_state = FR_IDLE;
                            n_count = '0;
                        end
                    end else begin
                        n_pad_w = r_pad_w + 4'd1;
                    end
                end
            end
            default: begin
                n_state = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
            r_count <= '0;
            r_pad_w <= '0;
            r_first <= 1'b0;
            r_extra <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pad_w <= n_pad_w;
            r_first <= n_first;
            r_extra <= n_extra;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

>>> design/md5_back.sv
// ----------------------------------------------------------------------------
// MD5 back end
// Runs the 64 rounds on a queued block, one round a cycle, and emits digests.
// ----------------------------------------------------------------------------
module md5_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  md5_pkg::t_blk_status               i_status,
    output logic                               o_pop_blk,
    output logic [md5_pkg::RAM_AW-1:0]         o_raddr,
    input  logic [31:0]                        i_rdata,
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic [31:0]                        o_digest_word,
    output logic [1:0]                         o_word_index,
    output logic                               o_last_word
);
    import md5_pkg::*;

    t_back_state r_state, n_state;
    logic [31:0] r_chain [4];
    logic [31:0] n_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d, r_pre;
    logic [31:0] n_a, n_b, n_c, n_d, n_pre;
    logic [5:0]  r_round, n_round;
    logic [1:0]  r_widx,  n_widx;
    logic        r_last,  n_last;

    logic [31:0] w_f;
    logic [31:0] w_t;
    logic [63:0] w_rot;
    logic [5:0]  w_next;

    assign w_next = r_round + 6'd1;

    always_comb begin
        case (r_round[5:4])
            2'd0:    w_f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    w_f = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    w_f = r_b ^ r_c ^ r_d;
            default: w_f = r_c ^ (r_b | ~r_d);
        endcase
        w_t   = r_pre + w_f;
        w_rot = {w_t, w_t} << md5_s(r_round);
    end

    always_comb begin
        n_state   = r_state;
        n_chain   = r_chain;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_d       = r_d;
        n_pre     = r_pre;
        n_round   = r_round;
        n_widx    = r_widx;
        n_last    = r_last;
        o_pop_blk = 1'b0;
        o_empty   = 1'b1;
        o_raddr   = {i_status.bank, md5_g(6'd0)};
        case (r_state)
            BK_IDLE: begin
                if (i_status.avail) begin
                    n_state = BK_PRE0;
                    n_last  = i_status.last;
                end
            end
            BK_PRE0: begin
                n_state = BK_PRE1;
            end
            BK_PRE1: begin
                o_raddr = {i_status.bank, md5_g(6'd1)};
                n_a     = r_chain[0];
                n_b     = r_chain[1];
                n_c     = r_chain[2];
                n_d     = r_chain[3];
                n_pre   = r_chain[0] + SINE_ROM[0] + i_rdata;
                n_round = '0;
                n_state = BK_ROUND;
            end
            BK_ROUND: begin
                // read two rounds ahead; the sum for the next round is formed here
                o_raddr = {i_status.bank, md5_g(r_round + 6'd2)};
                n_a     = r_d;
                n_d     = r_c;
                n_c     = r_b;
                n_b     = r_b + w_rot[63:32];
                n_pre   = r_d + SINE_ROM[w_next] + i_rdata;
                n_round = w_next;
                if (r_round == 6'd63) begin
                    n_state = BK_ADD;
                end
            end
            BK_ADD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                o_pop_blk  = 1'b1;
                n_widx     = '0;
                n_state    = r_last ? BK_OUT : BK_IDLE;
            end
            BK_OUT: begin
                o_empty = 1'b0;
                if (i_pop) begin
                    if (r_widx == 2'd3) begin
                        n_chain[0] = IV_A;
                        n_chain[1] = IV_B;
                        n_chain[2] = IV_C;
                        n_chain[3] = IV_D;
                        n_widx     = '0;
                        n_state    = BK_IDLE;
                    end else begin
                        n_widx = r_widx + 2'd1;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_digest_word = swap_bytes(r_chain[r_widx]);
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_chain[0] <= IV_A;
            r_chain[1] <= IV_B;
            r_chain[2] <= IV_C;
            r_chain[3] <= IV_D;
            r_round    <= '0;
            r_widx     <= '0;
            r_last     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chain <= n_chain;
            r_round <= n_round;
            r_widx  <= n_widx;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_pre <= n_pre;
    end

endmodule

>>> design/md5_message_digest.sv
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-stream MD5 with a two-block queue between the packer and the rounds.
// ----------------------------------------------------------------------------
// The input side takes one item a cycle (one optional message byte, plus an end
// marker) while a block bank is free. Bytes are packed little-endian into
// 16-word blocks held in a two-bank RAM; the front end hands each full bank to
// the round engine, which runs 64 rounds at one a cycle; for each block it
// passes through a start step, the read-ahead steps PRE0 and PRE1, the 64
// rounds and a final add.
// Byte loading of the next block overlaps compression of the current one.
// On an end marker the front end stalls input while it writes the 0x80 byte,
// zero padding and the 64-bit bit length (one or two blocks); the stall lasts
// longer while both banks are taken. After the final block four results are
// offered, words A to D each byte-reversed, with last_word set on D; the engine
// holds until all four have been transferred, then returns to the initial
// chaining value.
module md5_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_message_end,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);
    import md5_pkg::*;

    `include "md5_message_digest_defines.svh"

    // block queue bookkeeping: filled banks, bank pointers, final-block flags
    logic [1:0]  r_filled;
    logic        r_wbank;
    logic        r_rbank;
    logic [1:0]  r_last;

    t_blk_push   w_push;
    t_blk_status w_status;
    t_ram_wr     w_wr;
    logic        w_pop;
    logic        w_room;
    logic [RAM_AW-1:0] w_raddr;
    logic [31:0] w_rdata;

    assign w_room          = (r_filled != 2'd2);
    assign w_status.avail  = (r_filled != 2'd0);
    assign w_status.last   = r_last[r_rbank];
    assign w_status.bank   = r_rbank;

    md5_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_message_end  (i_message_end),
        .i_room         (w_room),
        .i_wbank        (r_wbank),
        .o_wr           (w_wr),
        .o_blk          (w_push)
    );

    md5_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.en),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    md5_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_status      (w_status),
        .o_pop_blk     (w_pop),
        .o_raddr       (w_raddr),
        .i_rdata       (w_rdata),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_wbank  <= 1'b0;
            r_rbank  <= 1'b0;
            r_last   <= '0;
        end else begin
            if (w_push.push) begin
                r_last[r_wbank] <= w_push.last;
                r_wbank         <= !r_wbank;
            end
            if (w_pop) begin
                r_rbank <= !r_rbank;
            end
            case ({w_push.push, w_pop})
                2'b10:   r_filled <= r_filled + 2'd1;
                2'b01:   r_filled <= r_filled - 2'd1;
                default: r_filled <= r_filled;
            endcase
        end
    end

    // front end must never complete a block into a full queue
    `MD5_NEVER(a_push_when_full, w_push.push && (r_filled == 2'd2), "block pushed into full queue")
    // engine must never retire a block it was not given
    `MD5_NEVER(a_pop_when_empty, w_pop && (r_filled == 2'd0), "block popped from empty queue")
    // a digest word is offered only once a final block has been retired
    `MD5_ASSERT(a_digest_after_final, $fell(o_empty) |-> $past(w_pop), "digest without block")

endmodule
